// File: rtl/els_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_pkg
// Shared constants and types for the echo latency statistics block.
// ----------------------------------------------------------------------------
package els_pkg;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int DELAY_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF   = 32;
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    localparam logic [1:0] ST_PROBE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    localparam logic ACT_PROBE = 1'b0;

    localparam logic [2:0] REG_TOKEN   = 3'd0;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;

    typedef struct packed {
        logic load;
        logic upd_probe;
        logic upd_illegal;
        logic upd_accept;
        logic div_mean_start;
        logic mean_apply;
        logic mul_start;
        logic var_apply;
        logic div_var_start;
        logic sqrt_start;
        logic std_apply;
    } t_cmd;

    typedef struct packed {
        logic is_probe;
        logic is_illegal;
        logic div_done;
        logic mul_done;
        logic sqrt_done;
        logic recv_zero;
    } t_sts;
endpackage

// File: rtl/els_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_ctrl
// Sequencer: steps the datapath through classify, mean, variance and std.
// ----------------------------------------------------------------------------
module els_ctrl
    import els_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_MEAN, S_MEANW, S_MUL, S_MULW, S_DVAR, S_DVARW,
        S_SQRT, S_SQRTW, S_OUT
    } t_state;

    t_state r_state;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.load = i_valid;
            S_CLASS: begin
                o_cmd.upd_probe   = i_sts.is_probe;
                o_cmd.upd_illegal = i_sts.is_illegal;
                o_cmd.upd_accept  = !i_sts.is_probe && !i_sts.is_illegal;
            end
            S_MEAN:  o_cmd.div_mean_start = 1'b1;
            S_MEANW: o_cmd.mean_apply = i_sts.div_done;
            S_MUL:   o_cmd.mul_start = 1'b1;
            S_MULW:  o_cmd.var_apply = i_sts.mul_done;
            S_DVAR:  o_cmd.div_var_start = !i_sts.recv_zero;
            S_DVARW: o_cmd.sqrt_start = i_sts.div_done;
            S_SQRTW: o_cmd.std_apply = i_sts.sqrt_done;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_CLASS;
                S_CLASS: begin
                    if (i_sts.is_probe || i_sts.is_illegal) r_state <= S_OUT;
                    else r_state <= S_MEAN;
                end
                S_MEAN:  r_state <= S_MEANW;
                S_MEANW: if (i_sts.div_done) r_state <= S_MUL;
                S_MUL:   r_state <= S_MULW;
                S_MULW:  if (i_sts.mul_done) r_state <= S_DVAR;
                S_DVAR: begin
                    if (i_sts.recv_zero) r_state <= S_OUT;
                    else r_state <= S_DVARW;
                end
                S_DVARW: if (i_sts.div_done) r_state <= S_SQRTW;
                S_SQRT:  r_state <= S_SQRTW;
                S_SQRTW: if (i_sts.sqrt_done) r_state <= S_OUT;
                S_OUT:   if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/els_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_dp
// Datapath: counters, min/max, shared 64-bit serial divider, 64x64
// multiplier (32x32 partial products), bit-pair integer square root.
// ----------------------------------------------------------------------------
module els_dp
    import els_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int DELAY_BITS   = DELAY_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [7:0]            i_echo_token,
    input  logic [22:0]           i_timeout_ms,
    input  logic                  i_action,
    input  logic [62:0]           i_now_ns,
    input  logic [15:0]           i_rx_length,
    input  logic [7:0]            i_rx_token,
    input  logic [62:0]           i_rx_sent_ns,
    output logic [1:0]            o_status,
    output logic [31:0]           o_stamp_sequence,
    output logic [62:0]           o_stamp_time_ns,
    output logic [31:0]           o_delay_ns,
    output logic [47:0]           o_mean_delay_q16,
    output logic [31:0]           o_min_delay_ns,
    output logic [31:0]           o_max_delay_ns,
    output logic [31:0]           o_std_delay_ns,
    output logic [31:0]           o_sent_total,
    output logic [31:0]           o_received_total,
    output logic [31:0]           o_illegal_total,
    output logic [31:0]           o_timeout_total
);
    localparam int MB = DELAY_BITS + 16;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [DELAY_BITS-1:0] DMAX = '1;

    logic                  r_action;
    logic [62:0]           r_now, r_sent;
    logic [15:0]           r_len;
    logic [7:0]            r_tok;
    logic [COUNT_BITS-1:0] r_sent_cnt, r_recv, r_ill, r_late;
    logic [MB-1:0]         r_mean;
    logic [63:0]           r_var;
    logic [DELAY_BITS-1:0] r_min, r_max, r_delay;
    logic [1:0]            r_status;
    logic [COUNT_BITS-1:0] r_seq;
    logic [62:0]           r_stamp;
    logic [31:0]           r_std;
    logic                  r_neg;
    logic [MB-1:0]         r_mag;
    logic [42:0]           r_timeout_mul;

    logic [62:0] raw;
    logic [42:0] tmo_ns;
    logic [MB-1:0] dq;
    logic [MB-1:0] mag_c;
    logic [COUNT_BITS-1:0] recv_inc;
    logic [DELAY_BITS-1:0] dly;

    assign raw    = (r_now >= r_sent) ? (r_now - r_sent) : 63'd0;
    assign tmo_ns = 43'(r_timeout_mul);
    assign dly    = (raw > 63'(DMAX)) ? DMAX : raw[DELAY_BITS-1:0];
    assign recv_inc = (r_recv == CMAX) ? CMAX : r_recv + 1'b1;
    assign dq     = {r_delay, 16'd0};
    assign mag_c  = (dq >= r_mean) ? dq - r_mean : r_mean - dq;

    always_ff @(posedge i_clk) r_timeout_mul <= i_timeout_ms * NS_PER_MS;

    // serial divider 64/COUNT_BITS
    logic [63:0] r_q, r_rem;
    logic [COUNT_BITS-1:0] r_dvs;
    logic [6:0] r_dcnt;
    logic r_dbusy, r_ddone;
    logic [64:0] rem_sh;
    assign rem_sh = {r_rem, r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_mean_start || i_cmd.div_var_start) begin
                r_q    <= i_cmd.div_mean_start ? 64'(mag_c) : r_var;
                r_rem  <= '0;
                r_dvs  <= r_recv;
                r_dcnt <= 7'd64;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (rem_sh >= 65'(r_dvs)) begin
                    r_rem <= 64'(rem_sh - 65'(r_dvs));
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[63:0];
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == 7'd1) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    // multiplier: floor(a*b/2^32) saturated, one 32x32 product per cycle
    logic [63:0] r_ma, r_mb;
    logic [2:0]  r_mcnt;
    logic [63:0] r_p00, r_p01, r_p10, r_p11, r_pp;
    logic        r_mbusy, r_mdone;
    logic [31:0] mx, my;
    always_comb begin
        case (r_mcnt)
            3'd4:    begin mx = r_ma[31:0];  my = r_mb[31:0];  end
            3'd3:    begin mx = r_ma[31:0];  my = r_mb[63:32]; end
            3'd2:    begin mx = r_ma[63:32]; my = r_mb[31:0];  end
            default: begin mx = r_ma[63:32]; my = r_mb[63:32]; end
        endcase
    end
    logic [33:0] mid;
    logic [65:0] hi;
    assign mid = 34'(r_p00[63:32]) + 34'(r_p01[31:0]) + 34'(r_p10[31:0]);
    assign hi  = 66'(r_p11) + 66'(r_p01[63:32]) + 66'(r_p10[63:32]) + 66'(mid[33:32]);
    logic [63:0] term;
    assign term = (hi[65:32] != 0) ? '1 : {hi[31:0], mid[31:0]};
    logic [64:0] vsum;
    assign vsum = 65'(r_var) + 65'(term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= 3'd4;
            end else if (r_mbusy) begin
                r_pp <= mx * my;
                case (r_mcnt)
                    3'd3:    r_p00 <= r_pp;
                    3'd2:    r_p01 <= r_pp;
                    3'd1:    r_p10 <= r_pp;
                    3'd0:    r_p11 <= r_pp;
                    default: ;
                endcase
                r_mcnt <= r_mcnt - 1'b1;
                if (r_mcnt == 3'd0) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    // integer square root, two bits per cycle
    logic [63:0] r_sv, r_sr, r_sbit;
    logic r_sbusy, r_sdone;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
        end else begin
            r_sdone <= 1'b0;
            if (i_cmd.sqrt_start) begin
                r_sv <= r_q;
                r_sr <= '0;
                r_sbit <= 64'd1 << 62;
                r_sbusy <= 1'b1;
            end else if (r_sbusy) begin
                if (r_sv >= r_sr + r_sbit) begin
                    r_sv <= r_sv - (r_sr + r_sbit);
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
                if (r_sbit == 64'd1) begin
                    r_sbusy <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_cnt <= '0;
            r_recv <= '0;
            r_ill <= '0;
            r_late <= '0;
            r_mean <= '0;
            r_var <= '0;
            r_min <= '0;
            r_max <= '0;
            r_std <= '0;
        end else begin
            if (i_cmd.load) begin
                r_action <= i_action;
                r_now <= i_now_ns;
                r_sent <= i_rx_sent_ns;
                r_len <= i_rx_length;
                r_tok <= i_rx_token;
            end
            if (i_cmd.upd_probe) begin
                r_status <= ST_PROBE;
                r_seq <= r_sent_cnt;
                r_stamp <= r_now;
                r_delay <= '0;
                r_sent_cnt <= r_sent_cnt + 1'b1;
            end
            if (i_cmd.upd_illegal) begin
                r_status <= ST_ILLEGAL;
                r_seq <= '0;
                r_stamp <= '0;
                r_delay <= '0;
                if (r_ill != CMAX) r_ill <= r_ill + 1'b1;
            end
            if (i_cmd.upd_accept) begin
                r_status <= ST_ACCEPT;
                r_seq <= '0;
                r_stamp <= '0;
                r_delay <= dly;
                r_recv <= recv_inc;
                if (raw > 63'(tmo_ns) && r_late != CMAX) r_late <= r_late + 1'b1;
                if (recv_inc == COUNT_BITS'(1)) begin
                    r_min <= dly;
                    r_max <= dly;
                end else begin
                    if (dly > r_max) r_max <= dly;
                    if (dly < r_min) r_min <= dly;
                end
            end
            if (i_cmd.mean_apply) begin
                if (!r_neg) r_mean <= r_mean + MB'(r_q);
                else        r_mean <= r_mean - MB'(r_q);
                r_ma <= 64'(r_mag);
                r_mb <= !r_neg ? 64'(dq - (r_mean + MB'(r_q)))
                               : 64'((r_mean - MB'(r_q)) - dq);
            end
            if (i_cmd.var_apply) r_var <= vsum[64] ? '1 : vsum[63:0];
            if (i_cmd.std_apply) r_std <= r_sr[31:0];
        end
    end

    // sign and magnitude of delay vs old mean, held until the mean update
    always_ff @(posedge i_clk) begin
        r_neg <= dq < r_mean;
        r_mag <= mag_c;
    end

    assign o_sts.is_probe   = (r_action == ACT_PROBE);
    assign o_sts.is_illegal = (r_action != ACT_PROBE) &&
        ((r_len < 16'(HEADER_BYTES)) || (r_tok != i_echo_token));
    assign o_sts.div_done   = r_ddone;
    assign o_sts.mul_done   = r_mdone;
    assign o_sts.sqrt_done  = r_sdone;
    assign o_sts.recv_zero  = (r_recv == '0);

    assign o_status         = r_status;
    assign o_stamp_sequence = 32'(r_seq);
    assign o_stamp_time_ns  = r_stamp;
    assign o_delay_ns       = 32'(r_delay);
    assign o_mean_delay_q16 = 48'(r_mean);
    assign o_min_delay_ns   = 32'(r_min);
    assign o_max_delay_ns   = 32'(r_max);
    assign o_std_delay_ns   = r_std;
    assign o_sent_total     = 32'(r_sent_cnt);
    assign o_received_total = 32'(r_recv);
    assign o_illegal_total  = 32'(r_ill);
    assign o_timeout_total  = 32'(r_late);
endmodule

// File: rtl/echo_latency_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_latency_statistics
// A probe or illegal echo goes from classify straight to the result. An
// accepted echo runs in order a 64-step serial divide for the mean, a
// 5-step multiply, a 64-step divide for the variance and a 32-step square
// root before its result is valid.
// One word in flight; next word taken the cycle after the result is taken.
// Synchronous active-low reset clears all counters and statistics,
// echo_token to 0 and timeout_ms to 1000.
// ----------------------------------------------------------------------------
module echo_latency_statistics
    import els_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int DELAY_BITS   = DELAY_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [62:0] i_now_ns,
    input  logic [15:0] i_rx_length,
    input  logic [7:0]  i_rx_token,
    input  logic [62:0] i_rx_sent_ns,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_stamp_sequence,
    output logic [62:0] o_stamp_time_ns,
    output logic [31:0] o_delay_ns,
    output logic [47:0] o_mean_delay_q16,
    output logic [31:0] o_min_delay_ns,
    output logic [31:0] o_max_delay_ns,
    output logic [31:0] o_std_delay_ns,
    output logic [31:0] o_sent_total,
    output logic [31:0] o_received_total,
    output logic [31:0] o_illegal_total,
    output logic [31:0] o_timeout_total
);
    logic [7:0]  r_token;
    logic [22:0] r_tmo;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= '0;
            r_tmo   <= 23'd1000;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_TOKEN:   r_token <= pwdata[7:0];
                REG_TIMEOUT: r_tmo   <= pwdata[22:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr)
            REG_TOKEN:   prdata = {24'd0, r_token};
            REG_TIMEOUT: prdata = {9'd0, r_tmo};
            default:     prdata = '0;
        endcase
    end

    els_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    els_dp #(
        .HEADER_BYTES(HEADER_BYTES), .DELAY_BITS(DELAY_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_echo_token(r_token), .i_timeout_ms(r_tmo),
        .i_action, .i_now_ns, .i_rx_length, .i_rx_token, .i_rx_sent_ns,
        .o_status, .o_stamp_sequence, .o_stamp_time_ns, .o_delay_ns,
        .o_mean_delay_q16, .o_min_delay_ns, .o_max_delay_ns, .o_std_delay_ns,
        .o_sent_total, .o_received_total, .o_illegal_total, .o_timeout_total
    );
endmodule

// File: rtl/els_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_checker
// Port-level checks on the result channel and counters.
// ----------------------------------------------------------------------------
module els_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_min_delay_ns,
    input logic [31:0] o_max_delay_ns,
    input logic [31:0] o_received_total
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while result pending");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
    a_mm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_received_total != 0 |-> o_min_delay_ns <= o_max_delay_ns)
        else $error("min above max");
endmodule

bind echo_latency_statistics els_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_ready, .o_status,
    .o_min_delay_ns, .o_max_delay_ns, .o_received_total
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the echo latency statistics block: directed probes and
// echoes at the field extremes, register settings, random traffic with random
// idling on both sides, receiver backpressure and a sender pause. Each result
// is checked field by field against a predicted latency statistics record.
// ----------------------------------------------------------------------------
module tb;
    import els_pkg::*;

    localparam logic       ACT_ECHO    = 1'b1;
    localparam logic [62:0] T_MAX      = {63{1'b1}};

    typedef struct {
        logic [1:0]  status;
        logic [31:0] seq;
        logic [62:0] stamp;
        logic [31:0] delay;
        logic [47:0] mean;
        logic [31:0] dmin;
        logic [31:0] dmax;
        logic [31:0] dstd;
        logic [31:0] sent;
        logic [31:0] recv;
        logic [31:0] bad;
        logic [31:0] late;
    } stats_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [62:0] i_now_ns = '0;
    logic [15:0] i_rx_length = '0;
    logic [7:0]  i_rx_token = '0;
    logic [62:0] i_rx_sent_ns = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_stamp_sequence, o_delay_ns, o_min_delay_ns, o_max_delay_ns;
    logic [62:0] o_stamp_time_ns;
    logic [47:0] o_mean_delay_q16;
    logic [31:0] o_std_delay_ns, o_sent_total, o_received_total;
    logic [31:0] o_illegal_total, o_timeout_total;

    echo_latency_statistics uut (.*);

    always #5 i_clk = ~i_clk;

    // predicted block state
    logic [7:0]  token_q;
    logic [22:0] timeout_q;
    logic [31:0] sent_q, recv_q, bad_q, late_q, min_q, max_q;
    logic [63:0] mean_q, var_q;

    stats_t expected_q[$];
    int     mismatches = 0;
    bit     no_idle = 0;
    bit     rx_hold = 0;

    always @(posedge i_clk) begin
        if (rx_hold) i_ready <= 1'b0;
        else i_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_up(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 1;
    endfunction

    function automatic stats_t latency_update(logic act, logic [62:0] now,
            logic [15:0] len, logic [7:0] tok, logic [62:0] sent);
        stats_t r;
        logic [62:0]  raw;
        logic [63:0]  dq, mag, dold, dnew, term;
        logic [127:0] prod;
        r = '{default: '0};
        if (act == ACT_PROBE) begin
            r.status = ST_PROBE;
            r.seq = sent_q;
            r.stamp = now;
            sent_q = sent_q + 1;
        end else if (len < 16'd24 || tok != token_q) begin
            r.status = ST_ILLEGAL;
            bad_q = sat_up(bad_q);
        end else begin
            r.status = ST_ACCEPT;
            raw = (now >= sent) ? now - sent : '0;
            r.delay = (raw > 63'hFFFF_FFFF) ? 32'hFFFF_FFFF : raw[31:0];
            recv_q = sat_up(recv_q);
            if (64'(raw) > 64'(timeout_q) * 64'd1000000) late_q = sat_up(late_q);
            if (recv_q == 1) begin
                min_q = r.delay;
                max_q = r.delay;
            end
            if (r.delay > max_q) max_q = r.delay;
            if (r.delay < min_q) min_q = r.delay;
            dq = 64'(r.delay) << 16;
            if (dq >= mean_q) begin
                mag = dq - mean_q;
                mean_q = mean_q + mag / recv_q;
                dold = mag;
                dnew = dq - mean_q;
            end else begin
                mag = mean_q - dq;
                mean_q = mean_q - mag / recv_q;
                dold = mag;
                dnew = mean_q - dq;
            end
            prod = (128'(dold) * 128'(dnew)) >> 32;
            term = (prod[127:64] != 0) ? '1 : prod[63:0];
            var_q = (var_q > ~term) ? '1 : var_q + term;
        end
        r.mean = mean_q[47:0];
        r.dmin = min_q;
        r.dmax = max_q;
        r.dstd = (recv_q != 0) ? 32'(int_sqrt(var_q / recv_q)) : '0;
        r.sent = sent_q;
        r.recv = recv_q;
        r.bad = bad_q;
        r.late = late_q;
        return r;
    endfunction

    function automatic void check_field(string nm, logic [63:0] exp_v,
            logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h actual %0h", nm, exp_v, act_v);
        end
    endfunction

    always @(negedge i_clk) begin
        stats_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: unexpected result word");
            end else begin
                e = expected_q.pop_front();
                check_field("status", 64'(e.status), 64'(o_status));
                check_field("stamp_sequence", 64'(e.seq), 64'(o_stamp_sequence));
                check_field("stamp_time_ns", 64'(e.stamp), 64'(o_stamp_time_ns));
                check_field("delay_ns", 64'(e.delay), 64'(o_delay_ns));
                check_field("mean_delay_q16", 64'(e.mean), 64'(o_mean_delay_q16));
                check_field("min_delay_ns", 64'(e.dmin), 64'(o_min_delay_ns));
                check_field("max_delay_ns", 64'(e.dmax), 64'(o_max_delay_ns));
                check_field("std_delay_ns", 64'(e.dstd), 64'(o_std_delay_ns));
                check_field("sent_total", 64'(e.sent), 64'(o_sent_total));
                check_field("received_total", 64'(e.recv), 64'(o_received_total));
                check_field("illegal_total", 64'(e.bad), 64'(o_illegal_total));
                check_field("timeout_total", 64'(e.late), 64'(o_timeout_total));
            end
        end
    end

    // entered and left just after a rising edge
    task automatic send_word(logic act, logic [62:0] now, logic [15:0] len,
            logic [7:0] tok, logic [62:0] sent);
        i_valid <= 1'b1;
        i_action <= act;
        i_now_ns <= now;
        i_rx_length <= len;
        i_rx_token <= tok;
        i_rx_sent_ns <= sent;
        do @(negedge i_clk); while (!o_ready);
        expected_q.push_back(latency_update(act, now, len, tok, sent));
        @(posedge i_clk);
        if (!no_idle && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == REG_TOKEN) token_q = data[7:0];
        else if (addr == REG_TIMEOUT) timeout_q = data[22:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    task automatic random_echo();
        logic [62:0] now, sent;
        logic [15:0] len;
        logic [7:0]  tok;
        int k;
        now = rand63();
        case ($urandom_range(9))
            0, 1, 2: sent = now - $urandom_range(0, 5000);
            3, 4:    sent = now - $urandom_range(0, 32'hFFFF_FFFF);
            5:       sent = now - 63'(timeout_q) * 1000000 + $urandom_range(0, 2) - 1;
            6:       sent = rand63();
            7:       sent = now + $urandom_range(1, 1000);
            default: sent = now - 63'({$urandom_range(0, 15), $urandom});
        endcase
        k = $urandom_range(9);
        len = (k == 0) ? 16'($urandom_range(0, 23)) : 16'($urandom);
        if (len < 24 && k != 0) len = 24;
        tok = ($urandom_range(9) == 0) ? 8'($urandom) : token_q;
        send_word(ACT_ECHO, now, len, tok, sent);
    endtask

    task automatic test_directed();
        send_word(ACT_PROBE, '0, '0, '0, '0);
        send_word(ACT_PROBE, T_MAX, 16'hFFFF, 8'hFF, T_MAX);
        send_word(ACT_ECHO, 63'd100, 16'd23, 8'd0, 63'd50);
        send_word(ACT_ECHO, 63'd100, 16'd0, 8'd0, 63'd50);
        send_word(ACT_ECHO, 63'd100, 16'd24, 8'd1, 63'd50);
        send_word(ACT_ECHO, 63'd5000, 16'd24, 8'd0, 63'd1000);
        send_word(ACT_ECHO, 63'd10, 16'hFFFF, 8'd0, 63'd900);
        send_word(ACT_ECHO, T_MAX, 16'd64, 8'd0, '0);
        send_word(ACT_ECHO, 63'd1000000001000, 16'd24, 8'd0, 63'd1000);
        send_word(ACT_ECHO, 63'd1000000001001, 16'd24, 8'd0, 63'd1000);
        send_word(ACT_ECHO, 63'd777, 16'd100, 8'd0, 63'd777);
        send_word(ACT_PROBE, 63'h2AAA_AAAA_AAAA_AAAA, 16'd0, 8'd0, '0);
        send_word(ACT_ECHO, 63'h4000_0000, 16'd24, 8'd0, 63'h1000);
    endtask

    task automatic test_registers();
        wait_drain();
        reg_write(REG_TOKEN, 32'hFF);
        reg_write(REG_TIMEOUT, 32'd0);
        send_word(ACT_ECHO, 63'd50, 16'd24, 8'hFF, 63'd50);
        send_word(ACT_ECHO, 63'd51, 16'd24, 8'hFF, 63'd50);
        send_word(ACT_ECHO, 63'd51, 16'd24, 8'h00, 63'd50);
        wait_drain();
        reg_write(REG_TOKEN, 32'hA5);
        reg_write(REG_TIMEOUT, 32'd4294967);
        send_word(ACT_ECHO, T_MAX, 16'd24, 8'hA5, '0);
        send_word(ACT_ECHO, 63'd4294967000000, 16'd24, 8'hA5, '0);
        send_word(ACT_ECHO, 63'd4294967000001, 16'd24, 8'hA5, '0);
    endtask

    task automatic test_random(int n, logic [7:0] tok, logic [22:0] tmo);
        wait_drain();
        reg_write(REG_TOKEN, 32'(tok));
        reg_write(REG_TIMEOUT, 32'(tmo));
        for (int i = 0; i < n; i++) begin
            no_idle = (i >= n / 2 && i < n / 2 + 40);
            if ($urandom_range(3) == 0) send_word(ACT_PROBE, rand63(), 16'($urandom),
                    8'($urandom), rand63());
            else random_echo();
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (600) @(posedge i_clk);
                rx_hold = 0;
            end
        join_none
        for (int i = 0; i < 8; i++) random_echo();
    endtask

    task automatic test_pause();
        for (int i = 0; i < 4; i++) random_echo();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 4; i++) random_echo();
    endtask

    initial begin
        token_q = '0;
        timeout_q = 23'd1000;
        {sent_q, recv_q, bad_q, late_q, min_q, max_q} = '0;
        mean_q = '0;
        var_q = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_registers();
        test_random(250, 8'h3C, 23'd2);
        test_backpressure();
        test_random(250, 8'h00, 23'd1);
        test_pause();
        test_random(300, 8'hC3, 23'd4294967);
        wait_drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("echo_latency_statistics regression: pass");
        end else begin
            $display("echo_latency_statistics regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("echo_latency_statistics regression: fail");
        $finish;
    end
endmodule
